// ===== rtl/capsule_header_validator_macros.svh =====
// Assertion macros for the capsule header validator checker.
`ifndef CAPSULE_HEADER_VALIDATOR_MACROS_SVH
`define CAPSULE_HEADER_VALIDATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chv_pkg.sv =====
// Types, constants and helper functions for the capsule header validator.
package chv_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CMP_W      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    localparam int HDR_MIN    = 28;
    localparam int GUID_BYTES = 16;
    localparam int OFF_FLAGS  = 20;
    localparam int OFF_ISIZE  = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [31:0] REFUSE_MASK_RESET = 32'h0001_0000;

    // FMP capsule GUID as it appears in the buffer, byte 0 in the low bits.
    localparam logic [127:0] FMP_GUID = 128'h2ad99a19_9471a1bd_4c44e82d_6dcbd5ed;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_SIZE    = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    function automatic logic [7:0] guid_byte(input logic [3:0] idx);
        return FMP_GUID[{idx, 3'b000} +: 8];
    endfunction

    // Replaces one byte lane of a little-endian word.
    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
        logic [31:0] res;
        res = word;
        for (int i = 0; i < 4; i++)
        begin
            if (lane == 2'(i))
            begin
                res[i*8 +: 8] = b;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/chv_ifs.sv =====
// Handshake channel interfaces for the capsule header validator.
interface chv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chv_result_if;
    logic              valid;
    logic              ready;
    chv_pkg::status_t  status;
    logic [31:0]       image_size;
    logic [31:0]       capsule_flags;

    modport source (output valid, output status, output image_size, output capsule_flags,
                    input ready);
    modport sink   (input valid, input status, input image_size, input capsule_flags,
                    output ready);
endinterface

interface chv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] refuse_flag_mask;

    modport source (output valid, output refuse_flag_mask, input ready);
    modport sink   (input valid, input refuse_flag_mask, output ready);
endinterface

// ===== rtl/capsule_header_validator.sv =====
// Capsule header validator: streams a capsule buffer byte by byte and checks its header.
// Throughput is one byte per cycle, except where a waiting result stalls a last byte.
// Each byte goes through an input register, then one pass updates the header state and,
// on the last byte, loads the result register; a waiting result only stalls a last byte.
// Asynchronous active-low reset empties both registers, clears the header state and sets
// the refuse mask to the persist-across-reset flag.
module capsule_header_validator
(
    input  logic                 clk,
    input  logic                 rst_n,
    chv_byte_if.sink             capsule,
    chv_result_if.source         verdict,
    chv_cfg_if.sink              cfg
);

    // Input register.
    logic                           in_valid_reg;
    logic [7:0]                     in_data_reg;
    logic                           in_last_reg;

    // Header state of the buffer in progress.
    logic [chv_pkg::COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic                           guid_ok_reg, guid_ok_next;
    logic [31:0]                    hsize_reg, hsize_next;
    logic [31:0]                    flags_reg, flags_next;
    logic [31:0]                    isize_reg, isize_next;

    logic [31:0]                    mask_reg;

    // Result register.
    logic                           out_valid_reg;
    chv_pkg::status_t               status_reg, status_next;
    logic [31:0]                    out_isize_reg, out_isize_next;
    logic [31:0]                    out_flags_reg, out_flags_next;

    logic                           advance;
    logic                           in_take;
    logic [chv_pkg::CMP_W-1:0]      len_cmp;
    logic [chv_pkg::CMP_W-1:0]      hsize_cmp;
    logic [chv_pkg::CMP_W-1:0]      isize_cmp;

    // A byte that ends a buffer needs room in the result register.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || verdict.ready);
    assign in_take = capsule.valid && capsule.ready;

    assign capsule.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    assign verdict.valid         = out_valid_reg;
    assign verdict.status        = status_reg;
    assign verdict.image_size    = out_isize_reg;
    assign verdict.capsule_flags = out_flags_reg;

    always_comb
    begin
        guid_ok_next = guid_ok_reg;
        hsize_next   = hsize_reg;
        flags_next   = flags_reg;
        isize_next   = isize_reg;

        if (byte_count_reg < chv_pkg::COUNT_BITS'(chv_pkg::GUID_BYTES))
        begin
            if (in_data_reg != chv_pkg::guid_byte(byte_count_reg[3:0]))
            begin
                guid_ok_next = 1'b0;
            end
        end
        else if (byte_count_reg < chv_pkg::COUNT_BITS'(chv_pkg::OFF_FLAGS))
        begin
            hsize_next = chv_pkg::put_byte(hsize_reg, byte_count_reg[1:0], in_data_reg);
        end
        else if (byte_count_reg < chv_pkg::COUNT_BITS'(chv_pkg::OFF_ISIZE))
        begin
            flags_next = chv_pkg::put_byte(flags_reg, byte_count_reg[1:0], in_data_reg);
        end
        else if (byte_count_reg < chv_pkg::COUNT_BITS'(chv_pkg::HDR_MIN))
        begin
            isize_next = chv_pkg::put_byte(isize_reg, byte_count_reg[1:0], in_data_reg);
        end

        if (byte_count_reg == chv_pkg::COUNT_MAX)
        begin
            byte_count_next = byte_count_reg;
        end
        else
        begin
            byte_count_next = byte_count_reg + chv_pkg::COUNT_BITS'(1);
        end
    end

    // Verdict on the buffer length that includes the current byte.
    always_comb
    begin
        len_cmp   = chv_pkg::CMP_W'(byte_count_next);
        hsize_cmp = chv_pkg::CMP_W'(hsize_next);
        isize_cmp = chv_pkg::CMP_W'(isize_next);

        if (byte_count_next < chv_pkg::COUNT_BITS'(chv_pkg::HDR_MIN))
        begin
            status_next = chv_pkg::ST_BAD_SIZE;
        end
        else if (!guid_ok_next)
        begin
            status_next = chv_pkg::ST_UNSUPPORTED;
        end
        else if ((flags_next & mask_reg) != 32'd0)
        begin
            status_next = chv_pkg::ST_UNSUPPORTED;
        end
        else if (hsize_next < 32'(chv_pkg::HDR_MIN) || hsize_cmp > len_cmp)
        begin
            status_next = chv_pkg::ST_BAD_SIZE;
        end
        else if (isize_next < hsize_next || isize_cmp > len_cmp)
        begin
            status_next = chv_pkg::ST_BAD_SIZE;
        end
        else
        begin
            status_next = chv_pkg::ST_OK;
        end

        if (status_next == chv_pkg::ST_OK)
        begin
            out_isize_next = isize_next;
            out_flags_next = flags_next;
        end
        else
        begin
            out_isize_next = 32'd0;
            out_flags_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_count_reg <= '0;
            guid_ok_reg    <= 1'b1;
            hsize_reg      <= 32'd0;
            flags_reg      <= 32'd0;
            isize_reg      <= 32'd0;
            mask_reg       <= chv_pkg::REFUSE_MASK_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                mask_reg <= cfg.refuse_flag_mask;
            end

            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdict.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_last_reg)
                begin
                    byte_count_reg <= '0;
                    guid_ok_reg    <= 1'b1;
                    hsize_reg      <= 32'd0;
                    flags_reg      <= 32'd0;
                    isize_reg      <= 32'd0;
                end
                else
                begin
                    byte_count_reg <= byte_count_next;
                    guid_ok_reg    <= guid_ok_next;
                    hsize_reg      <= hsize_next;
                    flags_reg      <= flags_next;
                    isize_reg      <= isize_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= capsule.data_byte;
            in_last_reg <= capsule.last_byte;
        end

        if (advance && in_last_reg)
        begin
            status_reg    <= status_next;
            out_isize_reg <= out_isize_next;
            out_flags_reg <= out_flags_next;
        end
    end

endmodule

// ===== rtl/chv_checker.sv =====
// Port-level assertions for the capsule header validator, bound to the top level.
`include "capsule_header_validator_macros.svh"

module chv_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              in_last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  chv_pkg::status_t  status,
    input  logic [31:0]       image_size,
    input  logic [31:0]       capsule_flags
);

    // A result that is not taken keeps its values.
    `CHV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(image_size) && $stable(capsule_flags), "stalled result changed")

    `CHV_ASSERT_SAME(a_status_legal, out_valid, status == chv_pkg::ST_OK || status == chv_pkg::ST_BAD_SIZE || status == chv_pkg::ST_UNSUPPORTED, "illegal status code")

    // Rejected capsules report no image size and no flags.
    `CHV_ASSERT_SAME(a_reject_zero, out_valid && status != chv_pkg::ST_OK, image_size == 32'd0 && capsule_flags == 32'd0, "rejected result carries fields")

    // A result only appears after a last-byte transaction has passed the input and result registers.
    `CHV_ASSERT_SAME(a_result_origin, $rose(out_valid), $past(in_valid && in_ready && in_last, 2), "result without a last byte")

endmodule

bind capsule_header_validator chv_checker u_chv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (capsule.valid),
    .in_ready      (capsule.ready),
    .in_last       (capsule.last_byte),
    .out_valid     (verdict.valid),
    .out_ready     (verdict.ready),
    .status        (verdict.status),
    .image_size    (verdict.image_size),
    .capsule_flags (verdict.capsule_flags)
);

// ===== dv/tb_capsule_header_validator.sv =====
// Self-checking testbench for the capsule header validator: byte stream in, one verdict out.
module tb_capsule_header_validator;

    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 35;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } capsule_byte_t;

    typedef struct packed {
        chv_pkg::status_t status;
        logic [31:0]      image_size;
        logic [31:0]      capsule_flags;
    } verdict_t;

    // Ways a generated capsule header is spoiled.
    typedef enum int {
        FLAW_GUID,
        FLAW_HSIZE_LOW,
        FLAW_HSIZE_HIGH,
        FLAW_ISIZE_LOW,
        FLAW_ISIZE_HIGH,
        FLAW_FLAGS
    } flaw_e;

    logic clk;
    logic rst_n;

    chv_byte_if   capsule_ch();
    chv_result_if verdict_ch();
    chv_cfg_if    mask_ch();

    capsule_header_validator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .capsule (capsule_ch),
        .verdict (verdict_ch),
        .cfg     (mask_ch)
    );

    capsule_byte_t bytes_to_send[$];
    verdict_t      verdicts_due[$];
    bit            steady_flow;
    int            errors;
    int            cycle_count;
    int            bytes_taken;
    int            capsules_taken;
    int            mask_settings;
    int            n_ok;
    int            n_bad_size;
    int            n_unsupported;

    // Running picture of the header parser.
    logic [chv_pkg::COUNT_BITS-1:0] seen_bytes;
    logic                           guid_ok;
    logic [31:0]                    hdr_size_word;
    logic [31:0]                    flags_word;
    logic [31:0]                    img_size_word;
    logic [31:0]                    refuse_mask;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_capsule();
        seen_bytes    = '0;
        guid_ok       = 1'b1;
        hdr_size_word = '0;
        flags_word    = '0;
        img_size_word = '0;
    endfunction

    // Folds one accepted byte into the header picture; a last byte yields a verdict.
    task automatic absorb_byte(input logic [7:0] b, input logic lst);
        verdict_t    v;
        logic [63:0] len;
        if (seen_bytes < chv_pkg::GUID_BYTES)
        begin
            if (chv_pkg::FMP_GUID[seen_bytes[3:0] * 8 +: 8] != b)
            begin
                guid_ok = 1'b0;
            end
        end
        else if (seen_bytes < chv_pkg::OFF_FLAGS)
        begin
            hdr_size_word[seen_bytes[1:0] * 8 +: 8] = b;
        end
        else if (seen_bytes < chv_pkg::OFF_ISIZE)
        begin
            flags_word[seen_bytes[1:0] * 8 +: 8] = b;
        end
        else if (seen_bytes < chv_pkg::HDR_MIN)
        begin
            img_size_word[seen_bytes[1:0] * 8 +: 8] = b;
        end
        if (seen_bytes != chv_pkg::COUNT_MAX)
        begin
            seen_bytes++;
        end
        if (lst)
        begin
            len = 64'(seen_bytes);
            if (len < chv_pkg::HDR_MIN)
                v.status = chv_pkg::ST_BAD_SIZE;
            else if (!guid_ok)
                v.status = chv_pkg::ST_UNSUPPORTED;
            else if ((flags_word & refuse_mask) != 0)
                v.status = chv_pkg::ST_UNSUPPORTED;
            else if (hdr_size_word < chv_pkg::HDR_MIN || 64'(hdr_size_word) > len)
                v.status = chv_pkg::ST_BAD_SIZE;
            else if (img_size_word < hdr_size_word || 64'(img_size_word) > len)
                v.status = chv_pkg::ST_BAD_SIZE;
            else
                v.status = chv_pkg::ST_OK;
            v.image_size    = (v.status == chv_pkg::ST_OK) ? img_size_word : 32'h0;
            v.capsule_flags = (v.status == chv_pkg::ST_OK) ? flags_word : 32'h0;
            verdicts_due.push_back(v);
            restart_capsule();
        end
    endtask

    // Builds one buffer: GUID, the three header words, then random payload; scramble makes every byte random.
    task automatic queue_capsule(input int len, input bit scramble, input int bad_pos,
                                 input logic [31:0] hsize, input logic [31:0] flags,
                                 input logic [31:0] isize);
        logic [7:0]  b;
        logic [95:0] fields;
        capsule_byte_t item;
        fields = {isize, flags, hsize};
        for (int i = 0; i < len; i++)
        begin
            if (scramble || i >= chv_pkg::HDR_MIN)
                b = 8'($urandom);
            else if (i < chv_pkg::GUID_BYTES)
                b = chv_pkg::FMP_GUID[i * 8 +: 8]
                    ^ ((i == bad_pos) ? 8'($urandom_range(1, 255)) : 8'h00);
            else
                b = fields[(i - chv_pkg::GUID_BYTES) * 8 +: 8];
            item.data = b;
            item.last = (i == len - 1);
            bytes_to_send.push_back(item);
        end
    endtask

    task automatic queue_random_capsules(input int min_bytes, input int min_capsules);
        int          queued;
        int          caps;
        int          len;
        int          bad_pos;
        int          pick;
        bit          scramble;
        flaw_e       flaw;
        logic [31:0] hsize;
        logic [31:0] flags;
        logic [31:0] isize;
        queued = 0;
        caps   = 0;
        while (queued < min_bytes || caps < min_capsules)
        begin
            pick     = $urandom_range(0, 99);
            scramble = 1'b0;
            bad_pos  = -1;
            len      = ($urandom_range(0, 14) == 0) ? $urandom_range(45, 160)
                                                    : $urandom_range(chv_pkg::HDR_MIN, 34);
            hsize    = $urandom_range(chv_pkg::HDR_MIN, len);
            isize    = $urandom_range(hsize, len);
            flags    = ($urandom_range(0, 3) == 0) ? 32'h0 : ($urandom & ~refuse_mask);
            if (pick >= 55 && pick < 80)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    flaw = flaw_e'($urandom_range(0, FLAW_FLAGS));
                    case (flaw)
                        FLAW_GUID:       bad_pos = $urandom_range(0, chv_pkg::GUID_BYTES - 1);
                        FLAW_HSIZE_LOW:  hsize = $urandom_range(0, chv_pkg::HDR_MIN - 1);
                        FLAW_HSIZE_HIGH: hsize = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                 : len + $urandom_range(1, 64);
                        FLAW_ISIZE_LOW:  isize = $urandom_range(0, hsize - 1);
                        FLAW_ISIZE_HIGH: isize = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                 : len + $urandom_range(1, 64);
                        // The lowest refused bit guarantees a hit whenever the mask is nonzero.
                        FLAW_FLAGS:      flags = $urandom | (refuse_mask & (~refuse_mask + 1));
                        default:         bad_pos = -1;
                    endcase
                end
            end
            else if (pick >= 80 && pick < 92)
            begin
                len = $urandom_range(1, chv_pkg::HDR_MIN - 1);
            end
            else if (pick >= 92)
            begin
                len      = $urandom_range(1, 60);
                scramble = 1'b1;
            end
            queue_capsule(len, scramble, bad_pos, hsize, flags, isize);
            queued += len;
            caps++;
        end
    endtask

    // Holds the sender off until every verdict is in and the pipeline has emptied.
    // The check runs between edges so that a byte handed over at an edge is already visible.
    task automatic wait_drained();
        @(negedge clk);
        while (bytes_to_send.size() != 0 || capsule_ch.valid || verdicts_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_refuse_mask(input logic [31:0] m);
        @(posedge clk);
        mask_ch.valid            <= 1'b1;
        mask_ch.refuse_flag_mask <= m;
        @(posedge clk);
        while (!mask_ch.ready)
        begin
            @(posedge clk);
        end
        mask_ch.valid <= 1'b0;
        refuse_mask = m;
        mask_settings++;
    endtask

    // Byte driver.
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        capsule_byte_t item;
        if (!rst_n)
        begin
            capsule_ch.valid     <= 1'b0;
            capsule_ch.data_byte <= 8'h00;
            capsule_ch.last_byte <= 1'b0;
        end
        else
        begin
            if (capsule_ch.valid && capsule_ch.ready)
            begin
                absorb_byte(capsule_ch.data_byte, capsule_ch.last_byte);
                bytes_taken++;
                if (capsule_ch.last_byte)
                begin
                    capsules_taken++;
                end
            end
            if (!capsule_ch.valid || capsule_ch.ready)
            begin
                if (bytes_to_send.size() != 0
                    && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    item = bytes_to_send.pop_front();
                    capsule_ch.valid     <= 1'b1;
                    capsule_ch.data_byte <= item.data;
                    capsule_ch.last_byte <= item.last;
                end
                else
                begin
                    capsule_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor and back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : watch_verdicts
        verdict_t want;
        if (!rst_n)
        begin
            verdict_ch.ready <= 1'b0;
        end
        else
        begin
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected verdict, got status %0d image_size %h flags %h",
                             $time, verdict_ch.status, verdict_ch.image_size,
                             verdict_ch.capsule_flags);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict_ch.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, verdict_ch.status);
                    end
                    if (verdict_ch.image_size !== want.image_size)
                    begin
                        errors++;
                        $display("%0t: image_size mismatch, expected %h, got %h",
                                 $time, want.image_size, verdict_ch.image_size);
                    end
                    if (verdict_ch.capsule_flags !== want.capsule_flags)
                    begin
                        errors++;
                        $display("%0t: capsule_flags mismatch, expected %h, got %h",
                                 $time, want.capsule_flags, verdict_ch.capsule_flags);
                    end
                    case (want.status)
                        chv_pkg::ST_OK:       n_ok++;
                        chv_pkg::ST_BAD_SIZE: n_bad_size++;
                        default:              n_unsupported++;
                    endcase
                end
            end
            verdict_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit with %0d verdicts outstanding",
                     $time, verdicts_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] mask_setting;
        rst_n                    = 1'b0;
        capsule_ch.valid         = 1'b0;
        capsule_ch.data_byte     = 8'h00;
        capsule_ch.last_byte     = 1'b0;
        verdict_ch.ready         = 1'b0;
        mask_ch.valid            = 1'b0;
        mask_ch.refuse_flag_mask = 32'h0;
        steady_flow              = 1'b0;
        refuse_mask              = chv_pkg::REFUSE_MASK_RESET;
        restart_capsule();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed buffers under the reset mask.
        queue_capsule(1, 1'b1, -1, 32'h0, 32'h0, 32'h0);
        queue_capsule(chv_pkg::HDR_MIN - 1, 1'b0, -1, chv_pkg::HDR_MIN, 32'h0,
                      chv_pkg::HDR_MIN);
        queue_capsule(chv_pkg::HDR_MIN, 1'b0, -1, chv_pkg::HDR_MIN, 32'h0, chv_pkg::HDR_MIN);
        queue_capsule(chv_pkg::HDR_MIN, 1'b0, -1, chv_pkg::HDR_MIN,
                      chv_pkg::REFUSE_MASK_RESET, chv_pkg::HDR_MIN);
        queue_capsule(30, 1'b0, chv_pkg::GUID_BYTES - 1, 30, 32'h0, 30);
        queue_capsule(30, 1'b0, -1, 30, ~chv_pkg::REFUSE_MASK_RESET, 30);
        queue_capsule(chv_pkg::HDR_MIN, 1'b0, -1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        queue_random_capsules(90, 3);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            mask_setting = (p == 0) ? 32'h0 :
                           (p == 1) ? 32'hFFFF_FFFF :
                           (p == 2) ? $urandom : (32'h1 << $urandom_range(0, 31));
            load_refuse_mask(mask_setting);
            // One whole phase runs with neither side idling.
            steady_flow = (p == 0);
            queue_random_capsules(90, 3);
            wait_drained();
        end
        steady_flow = 1'b0;
        repeat (8) @(posedge clk);

        $display("Checked %0d verdicts (%0d success, %0d bad size, %0d unsupported)",
                 n_ok + n_bad_size + n_unsupported, n_ok, n_bad_size, n_unsupported);
        $display("from %0d capsule bytes in %0d buffers over %0d refuse-mask settings.",
                 bytes_taken, capsules_taken, mask_settings + 1);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
